@@ hdl/note_event_scheduler_assert.svh @@
// Assertion macros used by the note event scheduler top level.
`ifndef NOTE_EVENT_SCHEDULER_ASSERT_SVH
`define NOTE_EVENT_SCHEDULER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define NES_ASSERT(label, clk, rstn, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define NES_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define NES_ASSERT(label, clk, rstn, prop, msg)
`define NES_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

@@ hdl/nes_pkg.sv @@
// Types and constants of the note event scheduler.
package nes_pkg;
    localparam int MAX_NOTES_DEF  = 32;
    localparam int MAX_EVENTS_DEF = 64;
    localparam int TIME_W         = 48;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        K_ADD    = 2'd0,
        K_REMOVE = 2'd1,
        K_CLEAR  = 2'd2,
        K_COMPILE = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] start_tick;
        logic [31:0] length_ticks;
        logic [6:0]  pitch;
        logic [15:0] velocity;
        logic [7:0]  track;
        logic [5:0]  note_index;
    } t_in;

    typedef struct packed {
        logic              status;
        logic              has_event;
        logic [TIME_W-1:0] event_time;
        logic              is_note_off;
        logic [6:0]        event_pitch;
        logic [15:0]       event_velocity;
        logic [7:0]        event_track;
        logic              last;
    } t_out;

    typedef struct packed {
        logic [31:0] start_tick;
        logic [31:0] length_ticks;
        logic [6:0]  pitch;
        logic [15:0] velocity;
        logic [7:0]  track;
    } t_note;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_REM,
        S_REM_WR,
        S_CLR,
        S_CMP_RD,
        S_CMP_ON,
        S_CMP_OFF,
        S_FLUSH,
        S_OUT_RD,
        S_OUT_DAT,
        S_RESP
    } t_state;
endpackage

@@ hdl/nes_note_mem.sv @@
// Note table memory: one write port and one registered read port.
module nes_note_mem #(
    parameter int DEPTH = nes_pkg::MAX_NOTES_DEF,
    parameter int AW    = 5
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  nes_pkg::t_note i_wdata,
    input  logic           i_re,
    input  logic [AW-1:0]  i_raddr,
    output nes_pkg::t_note o_rdata
);
    nes_pkg::t_note r_mem [DEPTH];
    nes_pkg::t_note r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/nes_conv.sv @@
// Tick to sample conversion: two multiplies, then round, add and saturate.
module nes_conv #(
    parameter int TAG_W = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [32:0]                i_tick,
    input  logic [TAG_W-1:0]           i_tag,
    input  logic [31:0]                i_spt,
    output logic                       o_valid,
    output logic [nes_pkg::TIME_W-1:0] o_key,
    output logic [TAG_W-1:0]           o_tag
);
    logic                       r_v1, r_v2;
    logic [48:0]                r_phi, r_plo;
    logic [TAG_W-1:0]           r_tag1, r_tag2;
    logic [nes_pkg::TIME_W-1:0] r_key;
    logic [49:0]                w_sum;

    assign w_sum = 50'(r_phi) + ((50'(r_plo) + 50'h8000) >> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phi  <= 49'(i_tick) * 49'(i_spt[31:16]);
        r_plo  <= 49'(i_tick) * 49'(i_spt[15:0]);
        r_tag1 <= i_tag;
        r_tag2 <= r_tag1;
        r_key  <= (w_sum > 50'(nes_pkg::TIME_MAX)) ? nes_pkg::TIME_MAX
                                                    : w_sum[nes_pkg::TIME_W-1:0];
    end

    assign o_valid = r_v2;
    assign o_key   = r_key;
    assign o_tag   = r_tag2;
endmodule

@@ hdl/nes_cell.sv @@
// One cell of the sorting chain: keeps the earlier event, passes the later one on.
module nes_cell #(
    parameter int TAG_W = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  nes_pkg::t_cell_ctl         i_ctl,
    input  logic                       i_in_v,
    input  logic [nes_pkg::TIME_W-1:0] i_in_key,
    input  logic [TAG_W-1:0]           i_in_tag,
    input  logic                       i_next_v,
    input  logic [nes_pkg::TIME_W-1:0] i_next_key,
    input  logic [TAG_W-1:0]           i_next_tag,
    output logic                       o_held_v,
    output logic [nes_pkg::TIME_W-1:0] o_held_key,
    output logic [TAG_W-1:0]           o_held_tag,
    output logic                       o_pass_v,
    output logic [nes_pkg::TIME_W-1:0] o_pass_key,
    output logic [TAG_W-1:0]           o_pass_tag
);
    logic                       r_hv, r_pv;
    logic [nes_pkg::TIME_W-1:0] r_hkey, r_pkey;
    logic [TAG_W-1:0]           r_htag, r_ptag;
    logic                       w_first;

    // The incoming event goes first when it is earlier, or a note-off tied with a note-on.
    // Between tied events of the same type the lower tag, which was generated first, wins,
    // so an event pushed down the chain keeps its place ahead of later ties.
    assign w_first = !r_hv || (i_in_key < r_hkey) ||
                     ((i_in_key == r_hkey) && i_in_tag[0] && !r_htag[0]) ||
                     ((i_in_key == r_hkey) && (i_in_tag[0] == r_htag[0]) &&
                      (i_in_tag < r_htag));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_hv <= 1'b0;
            r_pv <= 1'b0;
        end else if (i_ctl.shift) begin
            r_hv <= i_next_v;
            r_pv <= 1'b0;
        end else if (i_in_v) begin
            r_hv <= 1'b1;
            r_pv <= r_hv || !w_first;
        end else begin
            r_pv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_hkey <= i_next_key;
            r_htag <= i_next_tag;
        end else if (i_in_v && w_first) begin
            r_hkey <= i_in_key;
            r_htag <= i_in_tag;
            r_pkey <= r_hkey;
            r_ptag <= r_htag;
        end else begin
            r_pkey <= i_in_key;
            r_ptag <= i_in_tag;
        end
    end

    assign o_held_v   = r_hv;
    assign o_held_key = r_hkey;
    assign o_held_tag = r_htag;
    assign o_pass_v   = r_pv;
    assign o_pass_key = r_pkey;
    assign o_pass_tag = r_ptag;
endmodule

@@ hdl/note_event_scheduler.sv @@
// Top level of the note event scheduler: note table, control sequencer and sorting chain.
// Usage: items arrive on i_in (valid/stall); each item is an add, remove, clear-track or
// compile command. Results leave on o_out (valid/stall), one beat per result, with last
// set on the final beat of each item. The samples-per-tick register is written through
// i_cfg_we / i_cfg_data; the user must write it only while the block is idle, which the block does not enforce.
// Steps: an add passes S_ADD, then S_RESP; a remove passes S_REM, S_REM_WR and S_RESP
// (S_REM and S_RESP for a bad index); a clear track walks the stored notes in S_CLR,
// as the sequencer reads one table entry a cycle, then goes to S_RESP.
// Compile feeds the converter note by note through S_CMP_RD, S_CMP_ON and S_CMP_OFF, then
// waits in S_FLUSH for the converter and cell chain to settle, then passes S_OUT_RD and
// S_OUT_DAT for each event beat, since each beat needs a read of the note table through
// its single registered read port. Compile of an empty table gives one beat with no event.
// One item is worked on at a time; o_in_stall is low only while the sequencer is idle.
// A result beat waits in the output register, and the next item is taken meanwhile.
// Reset empties the note table count, clears the register to zero and clears all cell
// valid bits; no clearing pass is needed. While the receiver stalls, the output beat
// holds and the sequencer waits before loading the next one.
module note_event_scheduler #(
    parameter int MAX_NOTES  = nes_pkg::MAX_NOTES_DEF,
    parameter int MAX_EVENTS = nes_pkg::MAX_EVENTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  nes_pkg::t_in i_in,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output nes_pkg::t_out o_out,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_data
);
    localparam int NW        = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int CW        = $clog2(MAX_NOTES + 1);
    localparam int TAG_W     = NW + 1;
    localparam int NCAP      = MAX_EVENTS / 2;
    localparam int NCAP_C    = (NCAP < MAX_NOTES) ? NCAP : MAX_NOTES;
    localparam int FLUSH_LEN = MAX_EVENTS + 4;
    localparam int FW        = $clog2(FLUSH_LEN + 1);
    localparam int TW        = nes_pkg::TIME_W;

    nes_pkg::t_state r_state, n_state;
    nes_pkg::t_in    r_item;
    nes_pkg::t_out   r_out;
    logic            r_out_valid;
    logic [31:0]     r_spt;
    logic [CW-1:0]   r_total, r_i, r_k, n_comp;
    logic            r_rv, r_status;
    logic [FW-1:0]   r_flush;
    logic [TW-1:0]   r_ev_key;
    logic [TAG_W-1:0] r_ev_tag;

    logic            w_accept, w_out_free, w_add_bad, w_rem_bad, w_keep, w_load;
    logic            w_we, w_re, w_conv_v;
    logic [NW-1:0]   w_waddr, w_raddr;
    nes_pkg::t_note  w_wdata, w_rdata;
    logic [32:0]     w_tick;
    logic [TAG_W-1:0] w_conv_tag;
    nes_pkg::t_cell_ctl w_ctl;

    logic            w_cv;
    logic [TW-1:0]   w_ckey;
    logic [TAG_W-1:0] w_ctag;

    logic             w_hv [MAX_EVENTS];
    logic [TW-1:0]    w_hkey [MAX_EVENTS];
    logic [TAG_W-1:0] w_htag [MAX_EVENTS];
    logic             w_pv [MAX_EVENTS];
    logic [TW-1:0]    w_pkey [MAX_EVENTS];
    logic [TAG_W-1:0] w_ptag [MAX_EVENTS];

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_add_bad  = (r_total == CW'(MAX_NOTES)) || (r_item.length_ticks == 32'd0);
    assign w_rem_bad  = 7'(r_item.note_index) >= 7'(r_total);
    assign w_keep     = w_rdata.track != r_item.track;
    assign n_comp     = (r_total > CW'(NCAP_C)) ? CW'(NCAP_C) : r_total;
    // A result beat is loaded into the output register in this cycle.
    assign w_load     = w_out_free &&
                        ((r_state == nes_pkg::S_OUT_DAT) || (r_state == nes_pkg::S_RESP));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nes_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (nes_pkg::t_kind'(i_in.kind))
                        nes_pkg::K_ADD:     n_state = nes_pkg::S_ADD;
                        nes_pkg::K_REMOVE:  n_state = nes_pkg::S_REM;
                        nes_pkg::K_CLEAR:   n_state = nes_pkg::S_CLR;
                        nes_pkg::K_COMPILE: n_state = nes_pkg::S_CMP_RD;
                        default:            n_state = nes_pkg::S_IDLE;
                    endcase
                end
            end
            nes_pkg::S_ADD:    n_state = nes_pkg::S_RESP;
            nes_pkg::S_REM:    n_state = w_rem_bad ? nes_pkg::S_RESP : nes_pkg::S_REM_WR;
            nes_pkg::S_REM_WR: n_state = nes_pkg::S_RESP;
            nes_pkg::S_CLR: begin
                if ((r_i >= r_total) && !r_rv) begin
                    n_state = nes_pkg::S_RESP;
                end
            end
            nes_pkg::S_CMP_RD: begin
                if (r_i < n_comp) begin
                    n_state = nes_pkg::S_CMP_ON;
                end else if (r_i == '0) begin
                    n_state = nes_pkg::S_RESP;
                end else begin
                    n_state = nes_pkg::S_FLUSH;
                end
            end
            nes_pkg::S_CMP_ON:  n_state = nes_pkg::S_CMP_OFF;
            nes_pkg::S_CMP_OFF: n_state = nes_pkg::S_CMP_RD;
            nes_pkg::S_FLUSH: begin
                if (r_flush == FW'(FLUSH_LEN)) begin
                    n_state = nes_pkg::S_OUT_RD;
                end
            end
            nes_pkg::S_OUT_RD: n_state = nes_pkg::S_OUT_DAT;
            nes_pkg::S_OUT_DAT: begin
                if (w_out_free) begin
                    n_state = w_hv[0] ? nes_pkg::S_OUT_RD : nes_pkg::S_IDLE;
                end
            end
            nes_pkg::S_RESP: begin
                if (w_out_free) begin
                    n_state = nes_pkg::S_IDLE;
                end
            end
            default: n_state = nes_pkg::S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        w_we       = 1'b0;
        w_waddr    = r_total[NW-1:0];
        w_wdata    = w_rdata;
        w_re       = 1'b0;
        w_raddr    = r_i[NW-1:0];
        w_conv_v   = 1'b0;
        w_tick     = {1'b0, w_rdata.start_tick};
        w_conv_tag = {r_i[NW-1:0], 1'b0};
        w_ctl      = '0;
        o_in_stall = r_state != nes_pkg::S_IDLE;
        unique case (r_state)
            nes_pkg::S_ADD: begin
                w_we    = !w_add_bad;
                w_wdata = '{start_tick: r_item.start_tick, length_ticks: r_item.length_ticks,
                            pitch: r_item.pitch, velocity: r_item.velocity,
                            track: r_item.track};
            end
            nes_pkg::S_REM: begin
                w_re    = !w_rem_bad;
                w_raddr = NW'(r_total - CW'(1));
            end
            nes_pkg::S_REM_WR: begin
                w_we    = 1'b1;
                w_waddr = r_item.note_index[NW-1:0];
            end
            nes_pkg::S_CLR: begin
                w_re    = r_i < r_total;
                w_we    = r_rv && w_keep;
                w_waddr = r_k[NW-1:0];
            end
            nes_pkg::S_CMP_RD: begin
                w_re    = r_i < n_comp;
                w_ctl.clear = r_i == '0;
            end
            nes_pkg::S_CMP_ON: begin
                w_conv_v = 1'b1;
            end
            nes_pkg::S_CMP_OFF: begin
                w_conv_v   = 1'b1;
                w_tick     = {1'b0, w_rdata.start_tick} + {1'b0, w_rdata.length_ticks};
                w_conv_tag = {r_i[NW-1:0], 1'b1};
            end
            nes_pkg::S_OUT_RD: begin
                w_re      = 1'b1;
                w_raddr   = w_htag[0][TAG_W-1:1];
                w_ctl.shift = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nes_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_spt       <= '0;
            r_total     <= '0;
            r_i         <= '0;
            r_k         <= '0;
            r_rv        <= 1'b0;
            r_flush     <= '0;
            r_status    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_spt <= i_cfg_data;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                nes_pkg::S_IDLE: begin
                    r_i     <= '0;
                    r_k     <= '0;
                    r_rv    <= 1'b0;
                    r_flush <= '0;
                end
                nes_pkg::S_ADD: begin
                    r_status <= w_add_bad;
                    if (!w_add_bad) begin
                        r_total <= r_total + CW'(1);
                    end
                end
                nes_pkg::S_REM: r_status <= w_rem_bad;
                nes_pkg::S_REM_WR: r_total <= r_total - CW'(1);
                nes_pkg::S_CLR: begin
                    r_status <= 1'b0;
                    r_rv     <= r_i < r_total;
                    if (r_i < r_total) begin
                        r_i <= r_i + CW'(1);
                    end
                    if (r_rv && w_keep) begin
                        r_k <= r_k + CW'(1);
                    end
                    if ((r_i >= r_total) && !r_rv) begin
                        r_total <= r_k;
                    end
                end
                nes_pkg::S_CMP_RD: r_status <= 1'b0;
                nes_pkg::S_CMP_OFF: r_i <= r_i + CW'(1);
                nes_pkg::S_FLUSH: r_flush <= r_flush + FW'(1);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in;
        end
        if (r_state == nes_pkg::S_OUT_RD) begin
            r_ev_key <= w_hkey[0];
            r_ev_tag <= w_htag[0];
        end
        if (w_out_free && (r_state == nes_pkg::S_RESP)) begin
            r_out <= '{status: r_status, last: 1'b1, default: '0};
        end
        if (w_out_free && (r_state == nes_pkg::S_OUT_DAT)) begin
            r_out.status         <= 1'b0;
            r_out.has_event      <= 1'b1;
            r_out.event_time     <= r_ev_key;
            r_out.is_note_off    <= r_ev_tag[0];
            r_out.event_pitch    <= w_rdata.pitch;
            r_out.event_velocity <= r_ev_tag[0] ? 16'd0 : w_rdata.velocity;
            r_out.event_track    <= w_rdata.track;
            r_out.last           <= !w_hv[0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    nes_note_mem #(.DEPTH(MAX_NOTES), .AW(NW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    nes_conv #(.TAG_W(TAG_W)) u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_conv_v),
        .i_tick  (w_tick),
        .i_tag   (w_conv_tag),
        .i_spt   (r_spt),
        .o_valid (w_cv),
        .o_key   (w_ckey),
        .o_tag   (w_ctag)
    );

    // The converter feeds the head of the chain; shifting pulls the chain toward the head.
    for (genvar g = 0; g < MAX_EVENTS; g++) begin : g_cell
        nes_cell #(.TAG_W(TAG_W)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_in_v     ((g == 0) ? w_cv : w_pv[(g == 0) ? 0 : g - 1]),
            .i_in_key   ((g == 0) ? w_ckey : w_pkey[(g == 0) ? 0 : g - 1]),
            .i_in_tag   ((g == 0) ? w_ctag : w_ptag[(g == 0) ? 0 : g - 1]),
            .i_next_v   ((g == MAX_EVENTS - 1) ? 1'b0 : w_hv[(g == MAX_EVENTS - 1) ? g : g + 1]),
            .i_next_key (w_hkey[(g == MAX_EVENTS - 1) ? g : g + 1]),
            .i_next_tag (w_htag[(g == MAX_EVENTS - 1) ? g : g + 1]),
            .o_held_v   (w_hv[g]),
            .o_held_key (w_hkey[g]),
            .o_held_tag (w_htag[g]),
            .o_pass_v   (w_pv[g]),
            .o_pass_key (w_pkey[g]),
            .o_pass_tag (w_ptag[g])
        );
    end

`include "note_event_scheduler_assert.svh"
    `NES_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, w_accept, r_state != nes_pkg::S_IDLE, "accepted item did not start work")
    `NES_ASSERT(a_out_read_has_event, i_clk, i_rst_n, (r_state != nes_pkg::S_OUT_RD) || w_hv[0], "event read from an empty chain head")
    `NES_ASSERT_NEXT(a_add_counts, i_clk, i_rst_n, (r_state == nes_pkg::S_ADD) && !w_add_bad, r_total == $past(r_total) + CW'(1), "accepted add did not grow the table")
endmodule
